// ----- hw/rtl/rqs_pkg.sv -----
// Shared types and codes for the ring queue with sort unit.
package rqs_pkg;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;
    localparam logic [1:0] OP_SORT = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [31:0] DATA_NONE = -32'sd1;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic [3:0]         count;
    } response_t;

    typedef struct packed {
        logic accept;
        logic sorting;
        logic load;
        logic first;
        logic step;
        logic pass_end;
    } ctrl_cmd_t;

    typedef struct packed {
        logic short_sort;
        logic last_step;
        logic last_pass;
    } ctrl_sts_t;

endpackage

// ----- hw/rtl/rqs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rqs_ctrl.sv -----
// Controller state machine: accepts words and sequences the bubble sort passes.
module rqs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op,
    input  rqs_pkg::ctrl_sts_t sts,
    output rqs_pkg::ctrl_cmd_t cmd,
    output logic               busy
);
    import rqs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_END   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_SORT) && !sts.short_sort)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sts.last_step)
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                state_next = sts.last_pass ? S_IDLE : S_LOAD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.accept   = accept;
        cmd.sorting  = (state_reg != S_IDLE);
        cmd.load     = (state_reg == S_LOAD);
        cmd.first    = (state_reg == S_FIRST);
        cmd.step     = (state_reg == S_STEP);
        cmd.pass_end = (state_reg == S_END);
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- hw/rtl/rqs_datapath.sv -----
// Datapath: pointers, occupancy, storage RAM, sort compare and result registers.
module rqs_datapath #(
    parameter int DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rqs_pkg::request_t   request,
    input  rqs_pkg::ctrl_cmd_t  cmd,
    output rqs_pkg::ctrl_sts_t  sts,
    output rqs_pkg::response_t  response,
    output logic                done
);
    import rqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      tail_reg;
    logic [CW-1:0]      occ_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW-1:0]      wr_ptr_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      len_reg;
    logic signed [31:0] cur_reg;
    logic               done_reg;
    logic               use_ram_reg;
    logic [1:0]         status_reg;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [31:0]        wdata;
    logic [AW-1:0]      raddr;
    logic [31:0]        rdata;
    logic signed [31:0] rword;
    logic               greater;
    logic               full;
    logic               empty;
    logic [CW+3:0]      occ_ext;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
        next_slot = (slot == AW'(DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    assign rword   = $signed(rdata);
    assign greater = (cur_reg > rword);
    assign full    = (occ_reg == CW'(DEPTH));
    assign empty   = (occ_reg == '0);

    assign sts.short_sort = (occ_reg < CW'(2));
    assign sts.last_step  = ((idx_reg + CW'(1)) == len_reg);
    assign sts.last_pass  = (len_reg == CW'(2));

    assign raddr = cmd.sorting ? rd_ptr_reg : head_reg;
    assign waddr = cmd.sorting ? wr_ptr_reg : tail_reg;
    assign we    = (cmd.accept && (request.op == OP_ENQ) && !full) || cmd.step || cmd.pass_end;

    always_comb
    begin
        if (cmd.step)
        begin
            wdata = greater ? rdata : cur_reg;
        end
        else if (cmd.pass_end)
        begin
            wdata = cur_reg;
        end
        else
        begin
            wdata = request.value;
        end
    end

    rqs_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            len_reg     <= '0;
            done_reg    <= 1'b0;
            use_ram_reg <= 1'b0;
            status_reg  <= ST_OK;
        end
        else
        begin
            done_reg    <= 1'b0;
            use_ram_reg <= 1'b0;
            if (cmd.accept)
            begin
                status_reg <= ST_OK;
                case (request.op)
                    OP_ENQ:
                    begin
                        done_reg <= 1'b1;
                        if (full)
                        begin
                            status_reg <= ST_FULL;
                        end
                        else
                        begin
                            tail_reg <= next_slot(tail_reg);
                            occ_reg  <= occ_reg + CW'(1);
                        end
                    end
                    OP_DEQ:
                    begin
                        done_reg <= 1'b1;
                        if (empty)
                        begin
                            status_reg <= ST_EMPTY;
                        end
                        else
                        begin
                            use_ram_reg <= 1'b1;
                            occ_reg     <= occ_reg - CW'(1);
                            if (occ_reg == CW'(1))
                            begin
                                head_reg <= '0;
                                tail_reg <= '0;
                            end
                            else
                            begin
                                head_reg <= next_slot(head_reg);
                            end
                        end
                    end
                    OP_PEEK:
                    begin
                        done_reg <= 1'b1;
                        if (empty)
                        begin
                            status_reg <= ST_EMPTY;
                        end
                        else
                        begin
                            use_ram_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        len_reg <= occ_reg;
                        if (sts.short_sort)
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                endcase
            end
            if (cmd.pass_end)
            begin
                len_reg <= len_reg - CW'(1);
                if (sts.last_pass)
                begin
                    done_reg   <= 1'b1;
                    status_reg <= ST_OK;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept || cmd.pass_end)
        begin
            rd_ptr_reg <= head_reg;
            wr_ptr_reg <= head_reg;
        end
        if (cmd.load)
        begin
            rd_ptr_reg <= next_slot(rd_ptr_reg);
        end
        if (cmd.first)
        begin
            rd_ptr_reg <= next_slot(rd_ptr_reg);
            cur_reg    <= rword;
            idx_reg    <= CW'(1);
        end
        if (cmd.step)
        begin
            rd_ptr_reg <= next_slot(rd_ptr_reg);
            wr_ptr_reg <= next_slot(wr_ptr_reg);
            idx_reg    <= idx_reg + CW'(1);
            if (!greater)
            begin
                cur_reg <= rword;
            end
        end
    end

    assign occ_ext = {4'b0000, occ_reg};

    always_comb
    begin
        response.data   = use_ram_reg ? rword : DATA_NONE;
        response.status = status_reg;
        response.count  = occ_ext[3:0];
    end

    assign done = done_reg;

endmodule

// ----- hw/rtl/ring_queue_with_sort_unit.sv -----
// Top level of the ring queue with in-place sort.
//
// A word is taken on request when start is high and busy is low. request.op
// selects enqueue, dequeue, peek or sort; request.value is the word to enqueue.
// Exactly one response follows each accepted word: done is high for one cycle
// and response carries data, status and count. The receiver cannot stall;
// the response is valid only in the cycle done is high.
// Enqueue, dequeue and peek answer in the cycle after acceptance and keep
// busy low, so one such word can be accepted every cycle. The storage RAM
// has a registered read port, so the dequeued or peeked word arrives with it.
// Sort runs a bubble sort over the held words through the single RAM read
// port: with n words held it takes n-1 passes, each pass running the load,
// first, step and end states, with busy high throughout; the response
// follows in the cycle busy falls. Sort of zero or one word answers in
// the next cycle. Reset empties the queue; RAM contents are not cleared.
module ring_queue_with_sort_unit #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rqs_pkg::request_t  request,
    output logic               busy,
    output logic               done,
    output rqs_pkg::response_t response
);
    import rqs_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    rqs_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .op   (request.op),
        .sts  (sts),
        .cmd  (cmd),
        .busy (busy)
    );

    rqs_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .response(response),
        .done    (done)
    );

endmodule
